// File: rtl/core/hsm_pkg.sv
// Shared constants, codes and controller/datapath interface types for the hash set core.
package hsm_pkg;

   localparam int BUCKETS  = 1024;
   localparam int WAYS     = 4;
   localparam int KEY_BITS = 20;

   // bucket = key mod BUCKETS; BUCKETS is a power of two no wider than the key
   localparam int BUCKET_BITS  = $clog2(BUCKETS);
   localparam int WAY_IDX_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SLOT_BITS    = KEY_BITS + 1;
   localparam int ROW_BITS     = WAYS * SLOT_BITS;

   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_TEST   = 2'd2;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic clear_step;   // zero one bucket row, advance the sweep
      logic accept;       // capture request item, start bucket read
      logic commit;       // write bucket back, load result register
   } hsm_cmd_type;

   typedef struct packed {
      logic clear_last;   // sweep is at the last bucket row
   } hsm_sts_type;

endpackage

// File: rtl/core/hsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rd_data_ff;

endmodule

// File: rtl/core/hsm_datapath.sv
// Datapath: bucket table, slot compare, row update and result registers.
module hsm_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  hsm_pkg::hsm_cmd_type        cmd,
   output hsm_pkg::hsm_sts_type        sts,
   input  logic [1:0]                  req_mode,
   input  logic [hsm_pkg::KEY_BITS-1:0] req_key,
   output logic                        rsp_present,
   output logic                        rsp_status
);
   import hsm_pkg::*;

   logic [BUCKET_BITS-1:0]  clear_cnt_ff, clear_cnt_in;
   logic [1:0]              mode_ff;
   logic [KEY_BITS-1:0]     key_ff;
   logic                    present_ff;
   logic                    status_ff;

   logic                    ram_we;
   logic [BUCKET_BITS-1:0]  ram_waddr;
   logic [ROW_BITS-1:0]     ram_wdata;
   logic [ROW_BITS-1:0]     row_rd;
   logic [ROW_BITS-1:0]     row_wr;

   logic [KEY_BITS-1:0]     slot_key  [WAYS];
   logic                    slot_valid[WAYS];
   logic [KEY_BITS-1:0]     new_key   [WAYS];
   logic                    new_valid [WAYS];

   logic                    found;
   logic                    have_free;
   logic [WAY_IDX_BITS-1:0] hit_idx;
   logic [WAY_IDX_BITS-1:0] free_idx;
   logic                    status_in;

   hsm_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (BUCKETS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.accept),
      .raddr (req_key[BUCKET_BITS-1:0]),
      .rdata (row_rd)
   );

   // unpack bucket row and look for a matching slot and the lowest free slot
   always_comb begin
      found     = 1'b0;
      have_free = 1'b0;
      hit_idx   = '0;
      free_idx  = '0;
      for (int s = 0; s < WAYS; s++) begin
         slot_key[s]   = row_rd[s*SLOT_BITS +: KEY_BITS];
         slot_valid[s] = row_rd[s*SLOT_BITS + KEY_BITS];
      end
      for (int s = 0; s < WAYS; s++) begin
         if (slot_valid[s]) begin
            if (!found && slot_key[s] == key_ff) begin
               found   = 1'b1;
               hit_idx = WAY_IDX_BITS'(s);
            end
         end else if (!have_free) begin
            have_free = 1'b1;
            free_idx  = WAY_IDX_BITS'(s);
         end
      end
   end

   always_comb begin
      status_in = STATUS_DONE;
      for (int s = 0; s < WAYS; s++) begin
         new_key[s]   = slot_key[s];
         new_valid[s] = slot_valid[s];
      end
      case (mode_ff)
         MODE_ADD: begin
            if (!found) begin
               if (have_free) begin
                  new_key[free_idx]   = key_ff;
                  new_valid[free_idx] = 1'b1;
               end else begin
                  status_in = STATUS_FULL;
               end
            end
         end
         MODE_REMOVE: begin
            if (found) begin
               new_valid[hit_idx] = 1'b0;
            end
         end
         default: begin
            // test and the unused code leave the bucket as it is
         end
      endcase
      for (int s = 0; s < WAYS; s++) begin
         row_wr[s*SLOT_BITS +: KEY_BITS]   = new_key[s];
         row_wr[s*SLOT_BITS + KEY_BITS]    = new_valid[s];
      end
   end

   assign ram_we    = cmd.clear_step | cmd.commit;
   assign ram_waddr = cmd.clear_step ? clear_cnt_ff : key_ff[BUCKET_BITS-1:0];
   assign ram_wdata = cmd.clear_step ? '0 : row_wr;

   assign clear_cnt_in   = cmd.clear_step ? clear_cnt_ff + 1'b1 : clear_cnt_ff;
   assign sts.clear_last = (clear_cnt_ff == BUCKET_BITS'(BUCKETS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else begin
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff <= req_mode;
         key_ff  <= req_key;
      end
      if (cmd.commit) begin
         present_ff <= found;
         status_ff  <= status_in;
      end
   end

   assign rsp_present = present_ff;
   assign rsp_status  = status_ff;

endmodule

// File: rtl/core/hsm_ctrl.sv
// Controller: table clear sweep, request/lookup sequencing and result valid.
module hsm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hsm_pkg::hsm_cmd_type cmd,
   input  hsm_pkg::hsm_sts_type sts
);
   import hsm_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.clear_step = (state_ff == ST_CLEAR);
      cmd.accept     = (state_ff == ST_IDLE) && req_valid;
      // result register is free, or its item leaves this cycle
      cmd.commit     = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_ready);

      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (cmd.commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/core/hash_set_membership_core.sv
// Top level of the hash set core: bucketed key set with add, remove and test.
//
// Request channel (req_valid/req_ready): req_mode selects add, remove or test
// (the unused code tests), req_key is the key. Response channel
// (rsp_valid/rsp_ready): rsp_present tells whether the key was in the set
// before the item, rsp_status flags an add dropped because its bucket was full.
// Each key maps to bucket key mod BUCKETS, with WAYS slots per bucket held
// in one row of a single table RAM together with their valid marks.
// Sequence: an accepted item reads its bucket row from the table RAM, then in
// the lookup state writes the row back and loads the result register; no new
// item is accepted until that write back is done.
// Reset: the table is swept clear one row per cycle over its BUCKETS (1024)
// rows, with req_ready low during the sweep.
// Stalls: a new item is accepted while an earlier result waits in the output
// register; its lookup then holds until that result is taken.
module hash_set_membership_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_mode,
   input  logic [hsm_pkg::KEY_BITS-1:0] req_key,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_present,
   output logic                         rsp_status
);
   import hsm_pkg::*;

   hsm_cmd_type cmd;
   hsm_sts_type sts;

   hsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   hsm_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_mode    (req_mode),
      .req_key     (req_key),
      .rsp_present (rsp_present),
      .rsp_status  (rsp_status)
   );

endmodule

// File: rtl/core/hsm_checker.sv
// Port-level checks on the hash set core, bound to the top level.
module hsm_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_present,
   input logic rsp_status
);
   import hsm_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_present) && $stable(rsp_status))
      else $error("stalled result changed");

   // one item in flight: no accept in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("back-to-back accept");

   // table clear keeps the request side closed right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request accepted during table clear");

   // a full-bucket drop never reports the key as present
   a_full_not_present: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> !rsp_present)
      else $error("dropped add reported present");

   // a fresh result rises only after an accepted item has passed the lookup state
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a request item");

endmodule

bind hash_set_membership_core hsm_checker u_hsm_checker (.*);
